// ----- src/bmhq_pkg.sv -----
package bmhq_pkg;

  // Fixed field widths of the command and response transactions.
  localparam int KEY_W      = 32;
  localparam int TAG_PORT_W = 16;
  localparam int CNT_OUT_W  = 7;
  localparam int STATUS_W   = 2;

  // Command codes carried on in_tuser.
  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  // Status codes carried on out_tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_CMP   = 8'b0000_0010,
    S_EXT_ROOT = 8'b0000_0100,
    S_EXT_LAST = 8'b0000_1000,
    S_DN_LEFT  = 8'b0001_0000,
    S_DN_CMP   = 8'b0010_0000,
    S_WR_CUR   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

endpackage

// ----- src/bmhq_ram.sv -----
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/binary_max_heap_queue.sv -----
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    tdata: key, tag; tuser: command
// out_      master     out_tvalid/out_tready  tdata: key, tag, count; tuser: status
//
// An insert moves each smaller parent down as the new item climbs, at most log2(CAPACITY)
// levels. An extract returns the root and sinks the last item, reading the left and then the
// right child per level, both children sharing one memory read port; S_WR_CUR writes the item
// if it reaches the bottom. A rejected command goes straight to the response. Reset clears
// the count and control state only. A stalled response holds in the output register while the
// next command is accepted; that command waits at its end until the register frees.
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key_in [31:0], tag_in [47:32]
  input  logic        in_tuser,   // cmd [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // key_out [31:0], tag_out [47:32], count_out [54:48]
  output logic [1:0]  out_tuser   // status [1:0]
);

  localparam int TAG_W  = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam int ITEM_W = KEY_W + TAG_W;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = IDX_W + 2;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ITEM_W-1:0]    cur_r, cur_nxt;
  logic [ITEM_W-1:0]    lft_r, lft_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [KEY_W-1:0]     res_key_r, res_key_nxt;
  logic [TAG_W-1:0]     res_tag_r, res_tag_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [55:0]          out_data_r, out_data_nxt;
  status_t              out_status_r, out_status_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ITEM_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [ITEM_W-1:0]    mem_rdata;

  logic [CW-1:0]        pos_ext, cnt_ext, lft_idx, rgt_idx, big_idx, nxt_lft;
  logic                 rgt_ok, take_rgt;
  logic [ITEM_W-1:0]    big_item;
  logic [IDX_W-1:0]     par_idx;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;
  logic [ITEM_W-1:0]    in_item;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] i);
    parent_of = (i - IDX_W'(1)) >> 1;
  endfunction

  function automatic logic key_lt(input logic [ITEM_W-1:0] a, input logic [ITEM_W-1:0] b);
    key_lt = $signed(a[KEY_W-1:0]) < $signed(b[KEY_W-1:0]);
  endfunction

  // Heap storage.
  bmhq_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Index arithmetic around the current position.
  always_comb begin
    in_item  = {in_tdata[KEY_W +: TAG_W], in_tdata[KEY_W-1:0]};
    pos_ext  = CW'(pos_r);
    cnt_ext  = CW'(cnt_r);
    lft_idx  = (pos_ext << 1) + CW'(1);
    rgt_idx  = lft_idx + CW'(1);
    rgt_ok   = rgt_idx < cnt_ext;
    take_rgt = rgt_ok && key_lt(lft_r, mem_rdata);
    big_item = take_rgt ? mem_rdata : lft_r;
    big_idx  = take_rgt ? rgt_idx : lft_idx;
    nxt_lft  = (big_idx << 1) + CW'(1);
    par_idx  = parent_of(pos_r);
    cnt_wide = {{CNT_OUT_W{1'b0}}, cnt_r};
  end

  // Sequencer: one memory read per step; a sink step compares both children and the larger one.
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    lft_nxt        = lft_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = cur_r;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          if (cmd_t'(in_tuser) == CMD_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              cur_nxt = in_item;
              pos_nxt = cnt_r[IDX_W-1:0];
              cnt_nxt = cnt_r + CNT_W'(1);
              if (cnt_r == '0) begin
                state_nxt = S_WR_CUR;
              end else begin
                mem_raddr = parent_of(cnt_r[IDX_W-1:0]);
                state_nxt = S_UP_CMP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              mem_raddr = '0;
              cnt_nxt   = cnt_r - CNT_W'(1);
              state_nxt = S_EXT_ROOT;
            end
          end
        end
      end

      // Climb while the parent key is strictly smaller.
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (key_lt(mem_rdata, cur_r)) begin
          mem_wdata = mem_rdata;
          pos_nxt   = par_idx;
          if (par_idx == '0) begin
            state_nxt = S_WR_CUR;
          end else begin
            mem_raddr = parent_of(par_idx);
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Root is returned; the last item is fetched next.
      S_EXT_ROOT: begin
        res_key_nxt = mem_rdata[KEY_W-1:0];
        res_tag_nxt = mem_rdata[ITEM_W-1:KEY_W];
        mem_raddr   = cnt_r[IDX_W-1:0];
        state_nxt   = S_EXT_LAST;
      end

      S_EXT_LAST: begin
        cur_nxt = mem_rdata;
        pos_nxt = '0;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else if (cnt_r > CNT_W'(1)) begin
          mem_raddr = IDX_W'(1);
          state_nxt = S_DN_LEFT;
        end else begin
          state_nxt = S_WR_CUR;
        end
      end

      S_DN_LEFT: begin
        lft_nxt   = mem_rdata;
        mem_raddr = rgt_idx[IDX_W-1:0];
        state_nxt = S_DN_CMP;
      end

      // Sink while the larger child key is strictly greater.
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (key_lt(cur_r, big_item)) begin
          mem_wdata = big_item;
          pos_nxt   = big_idx[IDX_W-1:0];
          if (nxt_lft < cnt_ext) begin
            mem_raddr = nxt_lft[IDX_W-1:0];
            state_nxt = S_DN_LEFT;
          end else begin
            state_nxt = S_WR_CUR;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_WR_CUR: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end

      // Load the response register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {1'b0, cnt_wide[CNT_OUT_W-1:0],
                            TAG_PORT_W'(res_tag_r), res_key_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    lft_r        <= lft_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- src/bmhq_checker.sv -----
module bmhq_checker
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [CNT_OUT_W-1:0] CAP_LOW = CNT_OUT_W'(CAPACITY);

  // A stalled response transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("response changed while stalled");

  // A rejected command returns no item.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_EMPTY) |-> out_tdata[47:0] == '0)
    else $error("rejected command returned an item");

  // An insert is rejected only when the heap holds its full capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[54:48] == CAP_LOW)
    else $error("insert rejected below capacity");

  // An extract is rejected only when the heap is empty.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[54:48] == '0)
    else $error("extract rejected with items held");

  // An accepted command leaves the sequencer busy, with in_tready low right after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted on consecutive cycles");

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
